@@ hdl/mcss_pkg.sv @@
// ----------------------------------------------------------------------------
// Markov chain state sampler package
// Shared widths, command and register codes, and the channel word types.
// ----------------------------------------------------------------------------
package mcss_pkg;

   localparam int MAX_STATES = 16;
   localparam int STATE_BITS = $clog2(MAX_STATES);
   localparam int PROB_BITS  = 16;
   localparam int PROB_W     = PROB_BITS + 1;
   localparam int LEVEL_BITS = 20;
   localparam int SUM_W      = PROB_W + STATE_BITS;
   localparam int ADDR_W     = 2 * STATE_BITS;
   localparam int NUM_W      = STATE_BITS + 1;
   localparam int UNI_W      = 16;
   localparam int STEP_W     = 16;
   localparam int CSR_AW     = 4;
   localparam int CSR_DW     = 32;

   localparam logic [1:0] CMD_LOAD_PROB  = 2'd0;
   localparam logic [1:0] CMD_LOAD_LEVEL = 2'd1;
   localparam logic [1:0] CMD_RESTART    = 2'd2;
   localparam logic [1:0] CMD_STEP       = 2'd3;

   localparam logic [1:0] REG_NUM_STATES = 2'd0;
   localparam logic [1:0] REG_START      = 2'd1;
   localparam logic [1:0] REG_RUN_LENGTH = 2'd2;

   typedef struct packed {
      logic [1:0]            command;
      logic [STATE_BITS-1:0] row;
      logic [STATE_BITS-1:0] column;
      logic [PROB_W-1:0]     probability;
      logic [LEVEL_BITS-1:0] level;
      logic [UNI_W-1:0]      uniform;
   } req_type;

   typedef struct packed {
      logic [STATE_BITS-1:0] state_index;
      logic [LEVEL_BITS-1:0] state_level;
      logic [STEP_W-1:0]     timestep;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [STATE_BITS-1:0] row;
      logic [UNI_W-1:0]      uniform;
      logic [STATE_BITS-1:0] last_idx;
   } walk_req_type;

   typedef struct packed {
      logic                  done;
      logic [STATE_BITS-1:0] chosen;
   } walk_rsp_type;

endpackage

@@ hdl/mcss_prob_ram.sv @@
// ----------------------------------------------------------------------------
// Transition probability memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mcss_prob_ram (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [mcss_pkg::ADDR_W-1:0]       wr_addr,
   input  logic [mcss_pkg::PROB_W-1:0]       wr_data,
   input  logic [mcss_pkg::ADDR_W-1:0]       rd_addr,
   output logic [mcss_pkg::PROB_W-1:0]       rd_data
);

   logic [mcss_pkg::PROB_W-1:0] mem [mcss_pkg::MAX_STATES*mcss_pkg::MAX_STATES];
   logic [mcss_pkg::PROB_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/mcss_walk.sv @@
// ----------------------------------------------------------------------------
// Row walk sequencer
// Reads one row entry per cycle and feeds a single accumulate and compare
// unit until the running sum reaches the draw or the row is exhausted.
// ----------------------------------------------------------------------------
module mcss_walk (
   input  logic                            clock,
   input  logic                            reset,
   input  mcss_pkg::walk_req_type          walk_req,
   input  logic [mcss_pkg::PROB_W-1:0]     rd_data,
   output logic [mcss_pkg::ADDR_W-1:0]     rd_addr,
   output mcss_pkg::walk_rsp_type          walk_rsp
);

   typedef enum logic {S_IDLE, S_WALK} state_type;

   state_type                         state_ff, state_in;
   logic [mcss_pkg::STATE_BITS-1:0]   k_ff, k_in;
   logic [mcss_pkg::STATE_BITS-1:0]   chk_ff, chk_in;
   logic [mcss_pkg::STATE_BITS-1:0]   row_ff, row_in;
   logic [mcss_pkg::STATE_BITS-1:0]   last_ff, last_in;
   logic [mcss_pkg::STATE_BITS-1:0]   chosen_ff, chosen_in;
   logic [mcss_pkg::UNI_W-1:0]        u_ff, u_in;
   logic [mcss_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic                              issue_ff, issue_in;
   logic                              dv_ff, dv_in;
   logic                              done_ff, done_in;
   logic [mcss_pkg::SUM_W-1:0]        new_sum;
   logic                              finish;

   assign new_sum = sum_ff + mcss_pkg::SUM_W'(rd_data);
   assign finish  = dv_ff && ((new_sum >= mcss_pkg::SUM_W'(u_ff)) || (chk_ff == last_ff));

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      chk_in    = chk_ff;
      row_in    = row_ff;
      last_in   = last_ff;
      chosen_in = chosen_ff;
      u_in      = u_ff;
      sum_in    = sum_ff;
      issue_in  = issue_ff;
      dv_in     = 1'b0;
      done_in   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (walk_req.start) begin
               state_in = S_WALK;
               row_in   = walk_req.row;
               u_in     = walk_req.uniform;
               last_in  = walk_req.last_idx;
               k_in     = '0;
               sum_in   = '0;
               issue_in = 1'b1;
            end
         end
         S_WALK: begin
            if (issue_ff) begin
               dv_in  = 1'b1;
               chk_in = k_ff;
               if (k_ff == last_ff) begin
                  issue_in = 1'b0;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
            if (dv_ff) begin
               sum_in = new_sum;
            end
            if (finish) begin
               state_in  = S_IDLE;
               done_in   = 1'b1;
               chosen_in = chk_ff;
               issue_in  = 1'b0;
               dv_in     = 1'b0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         issue_ff <= 1'b0;
         dv_ff    <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         dv_ff    <= dv_in;
         done_ff  <= done_in;
      end
      k_ff      <= k_in;
      chk_ff    <= chk_in;
      row_ff    <= row_in;
      last_ff   <= last_in;
      chosen_ff <= chosen_in;
      u_ff      <= u_in;
      sum_ff    <= sum_in;
   end

   assign rd_addr         = {row_ff, k_ff};
   assign walk_rsp.done   = done_ff;
   assign walk_rsp.chosen = chosen_ff;

endmodule

@@ hdl/markov_chain_state_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// Markov chain state sampler
// Loads transition probabilities and state levels, restarts a run and steps
// the chain by inverse-CDF sampling of the current state's row.
// ----------------------------------------------------------------------------
//   Channel   Ports                          Carries
//   req       req_valid req_ready req_data   command word (load, restart, step)
//   rsp       rsp_valid rsp_ready rsp_data   state index, level, timestep, last
//   csr       psel penable pwrite paddr ...  num_states, start_index, run_length
//
// Loads write on acceptance. A restart's word waits in the pending flag
// until the output register is free. A step walks one row entry per cycle
// through the probability memory read port and then gives its word likewise.
// The sampler accepts no word while a step or a result awaiting the output
// register is in progress; a word held at the output does not stop loads.
// ----------------------------------------------------------------------------
module markov_chain_state_sampler_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mcss_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mcss_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mcss_pkg::CSR_AW-1:0]   paddr,
   input  logic [mcss_pkg::CSR_DW-1:0]   pwdata,
   output logic [mcss_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);

   logic [mcss_pkg::NUM_W-1:0]       num_states_ff, num_states_in;
   logic [mcss_pkg::STATE_BITS-1:0]  start_ff, start_in;
   logic [mcss_pkg::STEP_W-1:0]      run_len_ff, run_len_in;
   logic [mcss_pkg::STATE_BITS-1:0]  cur_ff, cur_in;
   logic [mcss_pkg::STEP_W-1:0]      cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             pend_ff, pend_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   mcss_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   logic [mcss_pkg::LEVEL_BITS-1:0]  level_ff [mcss_pkg::MAX_STATES];

   logic                             req_acc;
   logic                             csr_wr;
   logic                             out_free;
   logic [mcss_pkg::STATE_BITS-1:0]  last_idx;
   logic [mcss_pkg::ADDR_W-1:0]      rd_addr;
   logic [mcss_pkg::PROB_W-1:0]      rd_data;
   mcss_pkg::walk_req_type           walk_req;
   mcss_pkg::walk_rsp_type           walk_rsp;

   assign req_acc  = req_valid && req_ready;
   assign csr_wr   = psel && penable && pwrite;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (num_states_ff == '0) begin
         last_idx = '0;
      end else if (num_states_ff > mcss_pkg::NUM_W'(mcss_pkg::MAX_STATES)) begin
         last_idx = mcss_pkg::STATE_BITS'(mcss_pkg::MAX_STATES - 1);
      end else begin
         last_idx = mcss_pkg::STATE_BITS'(num_states_ff - 1'b1);
      end
   end

   assign walk_req.start    = req_acc && (req_data.command == mcss_pkg::CMD_STEP);
   assign walk_req.row      = cur_ff;
   assign walk_req.uniform  = req_data.uniform;
   assign walk_req.last_idx = last_idx;

   mcss_prob_ram u_prob_ram (
      .clock   (clock),
      .wr_en   (req_acc && (req_data.command == mcss_pkg::CMD_LOAD_PROB)),
      .wr_addr ({req_data.row, req_data.column}),
      .wr_data (req_data.probability),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mcss_walk u_walk (
      .clock    (clock),
      .reset    (reset),
      .walk_req (walk_req),
      .rd_data  (rd_data),
      .rd_addr  (rd_addr),
      .walk_rsp (walk_rsp)
   );

   always_comb begin
      num_states_in = num_states_ff;
      start_in      = start_ff;
      run_len_in    = run_len_ff;
      if (csr_wr) begin
         case (paddr[3:2])
            mcss_pkg::REG_NUM_STATES: num_states_in = pwdata[mcss_pkg::NUM_W-1:0];
            mcss_pkg::REG_START:      start_in      = pwdata[mcss_pkg::STATE_BITS-1:0];
            mcss_pkg::REG_RUN_LENGTH: run_len_in    = pwdata[mcss_pkg::STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         mcss_pkg::REG_NUM_STATES: prdata = mcss_pkg::CSR_DW'(num_states_ff);
         mcss_pkg::REG_START:      prdata = mcss_pkg::CSR_DW'(start_ff);
         mcss_pkg::REG_RUN_LENGTH: prdata = mcss_pkg::CSR_DW'(run_len_ff);
         default:                  prdata = '0;
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      busy_in      = busy_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_ff && out_free) begin
         pend_in                 = 1'b0;
         busy_in                 = 1'b0;
         rsp_valid_in            = 1'b1;
         rsp_data_in.state_index = cur_ff;
         rsp_data_in.state_level = level_ff[cur_ff];
         rsp_data_in.timestep    = cnt_ff;
         rsp_data_in.last        = (cnt_ff == run_len_ff);
      end
      if (walk_rsp.done) begin
         cur_in  = walk_rsp.chosen;
         cnt_in  = cnt_ff + 1'b1;
         pend_in = 1'b1;
      end
      if (req_acc) begin
         case (req_data.command)
            mcss_pkg::CMD_RESTART: begin
               cur_in  = start_ff;
               cnt_in  = '0;
               busy_in = 1'b1;
               pend_in = 1'b1;
            end
            mcss_pkg::CMD_STEP: begin
               busy_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff <= mcss_pkg::NUM_W'(2);
         start_ff      <= '0;
         run_len_ff    <= mcss_pkg::STEP_W'(1);
         cur_ff        <= '0;
         cnt_ff        <= '0;
         busy_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         num_states_ff <= num_states_in;
         start_ff      <= start_in;
         run_len_ff    <= run_len_in;
         cur_ff        <= cur_in;
         cnt_ff        <= cnt_in;
         busy_ff       <= busy_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      if (req_acc && (req_data.command == mcss_pkg::CMD_LOAD_LEVEL)) begin
         level_ff[req_data.row] <= req_data.level;
      end
   end

   assign req_ready = !busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;

endmodule
